// ===== design/assert_macros.svh =====
// Assertion macros shared by the splitter modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define HNS_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/hns_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the HEVC Annex B NAL splitter.
// No dependencies; used by every module of the block.
package hns_pkg;

    localparam logic [7:0]  START_BYTE     = 8'h01;
    localparam logic [15:0] INTERVAL_RESET = 16'd40;

    localparam logic [1:0]  ADDR_FRAME_INTERVAL = 2'd0;

    localparam logic [5:0] TYPE_BLA_W_LP   = 6'd16;
    localparam logic [5:0] TYPE_BLA_N_LP   = 6'd18;
    localparam logic [5:0] TYPE_IDR_W_RADL = 6'd19;
    localparam logic [5:0] TYPE_IDR_N_LP   = 6'd20;
    localparam logic [5:0] TYPE_CRA        = 6'd21;
    localparam logic [5:0] TYPE_VPS        = 6'd32;
    localparam logic [5:0] TYPE_PPS        = 6'd34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CLASS_P   = 2'd0,
        CLASS_IDR = 2'd1,
        CLASS_BLA = 2'd2,
        CLASS_CRA = 2'd3
    } frame_class_t;

    // Closed unit, passed from the parser to the formatter.
    typedef struct packed {
        logic [5:0]  nal_type;
        logic [31:0] unit_bytes;
        logic        eos;
    } unit_rec_t;

    function automatic frame_class_t class_of(input logic [5:0] t);
        frame_class_t c;
        c = CLASS_P;
        if (t == TYPE_IDR_W_RADL || t == TYPE_IDR_N_LP) begin
            c = CLASS_IDR;
        end else if (t >= TYPE_BLA_W_LP && t <= TYPE_BLA_N_LP) begin
            c = CLASS_BLA;
        end else if (t == TYPE_CRA) begin
            c = CLASS_CRA;
        end
        return c;
    endfunction

    function automatic logic is_param_set(input logic [5:0] t);
        return (t >= TYPE_VPS) && (t <= TYPE_PPS);
    endfunction

endpackage

// ===== design/hns_front.sv =====
`timescale 1ns / 1ps
// Parser: start code detection, header capture and unit length counting.
// Depends on hns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hns_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                end_of_stream,
    output logic                rec_push,
    output hns_pkg::unit_rec_t  rec
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]             zero_run_reg, zero_run_next;
    logic                   unit_open_reg, unit_open_next;
    logic                   hdr_pend_reg, hdr_pend_next;
    logic [5:0]             type_reg, type_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic [COUNT_WIDTH-1:0] count_inc;
    logic [COUNT_WIDTH-1:0] len;
    logic [63:0]            len_wide;
    logic [5:0]             rec_type;
    logic                   emit;
    logic                   accept;

    assign accept    = in_valid && in_ready;
    assign count_inc = (count_reg != CNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        zero_run_next  = zero_run_reg;
        unit_open_next = unit_open_reg;
        hdr_pend_next  = hdr_pend_reg;
        type_next      = type_reg;
        count_next     = count_reg;
        emit           = 1'b0;
        len            = count_reg;
        rec_type       = type_reg;

        priority if (unit_open_reg && hdr_pend_reg) begin
            type_next     = data_byte[6:1];
            hdr_pend_next = 1'b0;
            zero_run_next = 2'd0;
            count_next    = count_inc;
        end else if (!end_of_stream && data_byte == hns_pkg::START_BYTE
                     && zero_run_reg >= 2'd2) begin
            // leading zeros of the start code already counted into the old unit
            if (unit_open_reg) begin
                emit = 1'b1;
                if (count_reg != CNT_MAX) begin
                    len = count_reg - ((zero_run_reg == 2'd2) ? COUNT_WIDTH'(2)
                                                              : COUNT_WIDTH'(3));
                end
            end
            unit_open_next = 1'b1;
            hdr_pend_next  = 1'b1;
            type_next      = 6'd0;
            count_next     = (zero_run_reg == 2'd2) ? COUNT_WIDTH'(3) : COUNT_WIDTH'(4);
            zero_run_next  = 2'd0;
        end else begin
            if (unit_open_reg) begin
                count_next = count_inc;
            end
            if (data_byte == 8'd0) begin
                if (zero_run_reg != 2'd3) begin
                    zero_run_next = zero_run_reg + 2'd1;
                end
            end else begin
                zero_run_next = 2'd0;
            end
        end

        if (end_of_stream) begin
            if (unit_open_reg && !emit) begin
                emit     = 1'b1;
                len      = count_next;
                rec_type = type_next;
            end
            zero_run_next  = 2'd0;
            unit_open_next = 1'b0;
            hdr_pend_next  = 1'b0;
            type_next      = 6'd0;
            count_next     = '0;
        end
    end

    assign len_wide       = 64'(len);
    assign rec.nal_type   = rec_type;
    assign rec.unit_bytes = (|len_wide[63:32]) ? 32'hFFFF_FFFF : len_wide[31:0];
    assign rec.eos        = end_of_stream;
    assign rec_push       = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg  <= 2'd0;
            unit_open_reg <= 1'b0;
            hdr_pend_reg  <= 1'b0;
            type_reg      <= 6'd0;
            count_reg     <= '0;
        end else if (accept) begin
            zero_run_reg  <= zero_run_next;
            unit_open_reg <= unit_open_next;
            hdr_pend_reg  <= hdr_pend_next;
            type_reg      <= type_next;
            count_reg     <= count_next;
        end
    end

    `HNS_ASSERT_ALWAYS(a_hdr_needs_unit, aclk, aresetn, !hdr_pend_reg || unit_open_reg, "header pending without open unit")
    `HNS_ASSERT_NEXT(a_eos_clears, aclk, aresetn, accept && end_of_stream, !unit_open_reg && zero_run_reg == 2'd0, "state not cleared after end of stream")

endmodule

// ===== design/hns_queue.sv =====
`timescale 1ns / 1ps
// Short register queue of closed units between parser and formatter.
// Depends on hns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hns_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hns_pkg::unit_rec_t  push_rec,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output hns_pkg::unit_rec_t  head_rec
);

    hns_pkg::unit_rec_t                 slot_reg [hns_pkg::QUEUE_DEPTH];
    logic [hns_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [hns_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [hns_pkg::QUEUE_CNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == hns_pkg::QUEUE_CNT_W'(hns_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    `HNS_ASSERT_ALWAYS(a_no_overflow, aclk, aresetn, !(push && full), "request pushed into full queue")
    `HNS_ASSERT_ALWAYS(a_no_underflow, aclk, aresetn, !(pop && !not_empty), "pop from empty queue")

endmodule

// ===== design/hns_back.sv =====
`timescale 1ns / 1ps
// Formatter: frame class, timestamp and parameter-set flag, output register.
// Depends on hns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hns_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         frame_interval,
    input  logic                rec_avail,
    input  hns_pkg::unit_rec_t  rec,
    output logic                rec_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          nal_type,
    output logic [1:0]          frame_class,
    output logic [31:0]         unit_bytes,
    output logic [47:0]         time_stamp,
    output logic                param_set_kept
);

    logic [47:0] time_reg, time_next;
    logic        collect_reg, collect_next;
    logic        valid_reg, valid_next;
    logic [5:0]  type_reg;
    logic [1:0]  class_reg;
    logic [31:0] bytes_reg;
    logic [47:0] stamp_reg;
    logic        kept_reg;
    logic        rec_ps;

    assign rec_pop = rec_avail && (!valid_reg || out_ready);
    assign rec_ps  = hns_pkg::is_param_set(rec.nal_type);

    always_comb begin
        time_next    = time_reg;
        collect_next = collect_reg;
        valid_next   = valid_reg && !out_ready;
        if (rec_pop) begin
            valid_next = 1'b1;
            if (rec.eos) begin
                time_next    = 48'd0;
                collect_next = 1'b1;
            end else begin
                time_next    = time_reg + 48'(frame_interval);
                collect_next = collect_reg && rec_ps;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg    <= 48'd0;
            collect_reg <= 1'b1;
            valid_reg   <= 1'b0;
        end else begin
            time_reg    <= time_next;
            collect_reg <= collect_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            type_reg  <= rec.nal_type;
            class_reg <= hns_pkg::class_of(rec.nal_type);
            bytes_reg <= rec.unit_bytes;
            stamp_reg <= time_reg;
            kept_reg  <= rec_ps && collect_reg;
        end
    end

    assign out_valid      = valid_reg;
    assign nal_type       = type_reg;
    assign frame_class    = class_reg;
    assign unit_bytes     = bytes_reg;
    assign time_stamp     = stamp_reg;
    assign param_set_kept = kept_reg;

    `HNS_ASSERT_ALWAYS(a_kept_is_ps, aclk, aresetn, !(valid_reg && kept_reg) || hns_pkg::is_param_set(type_reg), "kept flag on non parameter set")
    `HNS_ASSERT_NEXT(a_eos_resets_time, aclk, aresetn, rec_pop && rec.eos, time_reg == 48'd0 && collect_reg, "timestamp not reset after stream end")

endmodule

// ===== design/hevc_annexb_nal_splitter.sv =====
`timescale 1ns / 1ps
// Top level of the HEVC Annex B NAL splitter: APB register, parser, queue, formatter.
// Depends on hns_pkg, hns_front, hns_queue and hns_back.
//
//  channel  | ports        | content
//  ---------+--------------+--------------------------------------------------
//  input    | s_t*         | one stream byte per request, tlast = end of stream
//  result   | m_t*         | one record per closed NAL unit
//  config   | p*           | frame_interval at byte address 0
//
// One byte is taken per cycle while s_tready is high; the parser state is registered on each accepted byte.
// A record is written into a queue slot, then popped into the output register once that register is free or taken.
// s_tready drops only while the four-entry record queue is full.
// aresetn is synchronous and active low; frame_interval resets to 40.
module hevc_annexb_nal_splitter #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [5:0] nal_type, [37:6] unit_bytes, [85:38] time_stamp, [87:86] 0
    output logic [2:0]  m_tuser    // [1:0] frame_class, [2] param_set_kept
);

    logic [15:0]        interval_reg;
    logic               rec_push;
    logic               rec_pop;
    logic               q_full;
    logic               q_avail;
    hns_pkg::unit_rec_t front_rec;
    hns_pkg::unit_rec_t head_rec;

    logic [5:0]  nal_type;
    logic [1:0]  frame_class;
    logic [31:0] unit_bytes;
    logic [47:0] time_stamp;
    logic        param_set_kept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= hns_pkg::INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr == hns_pkg::ADDR_FRAME_INTERVAL) begin
            interval_reg <= pwdata[15:0];
        end
    end

    assign pready   = 1'b1;
    assign prdata   = {16'd0, interval_reg};
    assign s_tready = !q_full;

    hns_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .rec_push      (rec_push),
        .rec           (front_rec)
    );

    hns_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_rec  (front_rec),
        .full      (q_full),
        .pop       (rec_pop),
        .not_empty (q_avail),
        .head_rec  (head_rec)
    );

    hns_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .frame_interval (interval_reg),
        .rec_avail      (q_avail),
        .rec            (head_rec),
        .rec_pop        (rec_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .nal_type       (nal_type),
        .frame_class    (frame_class),
        .unit_bytes     (unit_bytes),
        .time_stamp     (time_stamp),
        .param_set_kept (param_set_kept)
    );

    assign m_tdata = {2'b00, time_stamp, unit_bytes, nal_type};
    assign m_tuser = {param_set_kept, frame_class};

endmodule

// ===== tb/nal_record_checker.sv =====
`timescale 1ns / 1ps
// Checker for the HEVC Annex B NAL splitter: watches the byte, record and APB channels,
// predicts each unit record and compares it field by field. Depends on hns_pkg.
module nal_record_checker #(
    parameter logic [1:0] INTERVAL_ADDR = 2'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,   // [5:0] nal_type, [37:6] unit_bytes, [85:38] time_stamp
    input  logic [2:0]  m_tuser,   // [1:0] frame_class, [2] param_set_kept
    output int          fail_count,
    output int          pending,
    output int          records_checked
);

    typedef struct packed {
        logic [5:0]           nal_type;
        hns_pkg::frame_class_t frame_class;
        logic [31:0]          unit_bytes;
        logic [47:0]          time_stamp;
        logic                 ps_kept;
    } nal_record_t;

    nal_record_t expected_records[$];

    logic [15:0] interval;
    logic [1:0]  zero_run;
    logic        unit_open;
    logic        hdr_pending;
    logic [5:0]  cur_type;
    logic [31:0] byte_cnt;
    logic [47:0] time_acc;
    logic        collecting;

    function automatic void clear_stream();
        zero_run    = '0;
        unit_open   = 1'b0;
        hdr_pending = 1'b0;
        cur_type    = '0;
        byte_cnt    = '0;
        time_acc    = '0;
        collecting  = 1'b1;
    endfunction

    function automatic void close_unit(input logic [31:0] len);
        nal_record_t rec;
        logic        is_ps;
        is_ps = (cur_type >= hns_pkg::TYPE_VPS) && (cur_type <= hns_pkg::TYPE_PPS);
        rec.nal_type = cur_type;
        case (cur_type)
            hns_pkg::TYPE_IDR_W_RADL, hns_pkg::TYPE_IDR_N_LP: rec.frame_class = hns_pkg::CLASS_IDR;
            hns_pkg::TYPE_BLA_W_LP, hns_pkg::TYPE_BLA_W_LP + 6'd1,
            hns_pkg::TYPE_BLA_N_LP: rec.frame_class = hns_pkg::CLASS_BLA;
            hns_pkg::TYPE_CRA: rec.frame_class = hns_pkg::CLASS_CRA;
            default: rec.frame_class = hns_pkg::CLASS_P;
        endcase
        rec.unit_bytes = len;
        rec.time_stamp = time_acc;
        rec.ps_kept    = is_ps && collecting;
        if (!is_ps) begin
            collecting = 1'b0;
        end
        time_acc = time_acc + 48'(interval);
        expected_records.insert(expected_records.size(), rec);
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic eos);
        logic       closed;
        logic [2:0] sc_len;
        logic [31:0] len;
        closed = 1'b0;
        if (unit_open && hdr_pending) begin
            cur_type    = b[6:1];
            hdr_pending = 1'b0;
            zero_run    = '0;
            if (byte_cnt != '1) byte_cnt++;
        end else if (!eos && b == hns_pkg::START_BYTE && zero_run >= 2'd2) begin
            sc_len = (zero_run == 2'd2) ? 3'd3 : 3'd4;
            if (unit_open) begin
                // zeros of the start code were counted into the closing unit
                len = byte_cnt;
                if (len != '1) len = len - 32'(sc_len - 3'd1);
                close_unit(len);
                closed = 1'b1;
            end
            unit_open   = 1'b1;
            hdr_pending = 1'b1;
            cur_type    = '0;
            byte_cnt    = 32'(sc_len);
            zero_run    = '0;
        end else begin
            if (unit_open && byte_cnt != '1) byte_cnt++;
            if (b == 8'h00) begin
                if (zero_run != 2'd3) zero_run++;
            end else begin
                zero_run = '0;
            end
        end
        if (eos) begin
            if (unit_open && !closed) close_unit(byte_cnt);
            clear_stream();
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        nal_record_t want;
        if (!aresetn) begin
            interval = hns_pkg::INTERVAL_RESET;
            clear_stream();
            expected_records.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == INTERVAL_ADDR) begin
                interval = pwdata[15:0];
            end
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (expected_records.size() == 0) begin
                    $error("unexpected record request: m_tdata 0x%0h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_records.pop_front();
                    check_field("nal_type", 64'(want.nal_type), 64'(m_tdata[5:0]));
                    check_field("unit_bytes", 64'(want.unit_bytes), 64'(m_tdata[37:6]));
                    check_field("time_stamp", 64'(want.time_stamp), 64'(m_tdata[85:38]));
                    check_field("tdata_pad", 64'd0, 64'(m_tdata[87:86]));
                    check_field("frame_class", 64'(want.frame_class), 64'(m_tuser[1:0]));
                    check_field("param_set_kept", 64'(want.ps_kept), 64'(m_tuser[2]));
                    records_checked++;
                end
            end
            pending <= expected_records.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the NAL splitter testbench: clock, reset, APB writes, byte stream and record sink.
// Depends on hns_pkg, hevc_annexb_nal_splitter and nal_record_checker.
module testbench;

    localparam logic [1:0] INTERVAL_ADDR   = 2'd0;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         BYTES_PER_PHASE = 215;
    localparam int         SETTLE_CYCLES   = 8;

    typedef enum int {
        END_ON_PAYLOAD,
        END_ON_HEADER,
        END_ON_START_BYTE,
        END_ON_EXTRA
    } stream_end_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count;
    int pending;
    int records_checked;
    int bytes_sent;
    int streams_sent;
    int cycle_cnt;
    int rx_wait;
    bit burst;

    hevc_annexb_nal_splitter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nal_record_checker #(
        .INTERVAL_ADDR (INTERVAL_ADDR)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .records_checked (records_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // record sink: random stall after each accepted request
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (!m_tready) begin
            if (rx_wait <= 1) m_tready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end else if (m_tvalid) begin
            w = burst ? 0 : $urandom_range(0, 3);
            if (w != 0) m_tready <= 1'b0;
            rx_wait <= w;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] stream_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [5:0] pick_type();
        case ($urandom_range(0, 3))
            0: return hns_pkg::TYPE_BLA_W_LP + 6'($urandom_range(0, 5));
            1: return hns_pkg::TYPE_VPS + 6'($urandom_range(0, 2));
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    endfunction

    task automatic send_unit(input logic [5:0] t, input int plen, input bit last);
        int zeros;
        int i;
        zeros = $urandom_range(2, 3);
        if ($urandom_range(0, 7) == 0) zeros += $urandom_range(1, 3);
        repeat (zeros) send_byte(8'h00, 1'b0);
        send_byte(hns_pkg::START_BYTE, 1'b0);
        send_byte({1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1))}, last && plen == 0);
        for (i = 0; i < plen; i++) begin
            send_byte(stream_byte(), last && i == plen - 1);
        end
    endtask

    task automatic send_stream();
        int          n;
        int          n_ps;
        int          total;
        int          u;
        stream_end_t ending;
        streams_sent++;
        if ($urandom_range(0, 9) == 0) begin
            // noise: zero-heavy bytes, stray start bytes, random end-of-stream marks
            n = $urandom_range(4, 30);
            for (u = 0; u < n; u++) begin
                send_byte(($urandom_range(0, 4) == 0) ? hns_pkg::START_BYTE : stream_byte(),
                          (u == n - 1) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 39) == 0));
            end
        end else begin
            repeat ($urandom_range(0, 2)) send_byte(stream_byte(), 1'b0);
            n_ps   = $urandom_range(0, 3);
            total  = n_ps + $urandom_range(1, 5);
            ending = stream_end_t'($urandom_range(0, 3));
            for (u = 0; u < total; u++) begin
                send_unit((u < n_ps) ? hns_pkg::TYPE_VPS + 6'($urandom_range(0, 2)) : pick_type(),
                          pick_len(), ending == END_ON_PAYLOAD && u == total - 1);
            end
            case (ending)
                END_ON_HEADER: send_unit(pick_type(), 0, 1'b1);
                END_ON_START_BYTE: begin
                    send_byte(8'h00, 1'b0);
                    send_byte(8'h00, 1'b0);
                    send_byte(hns_pkg::START_BYTE, 1'b1);
                end
                END_ON_EXTRA: send_byte(stream_byte(), 1'b1);
                default: ;
            endcase
        end
    endtask

    // hold the stream until every predicted record has been taken, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= INTERVAL_ADDR;
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [7:0]  warmup[$];
        logic [15:0] intervals[$];
        int          i;
        int          target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // junk before first start code, 4-byte and 3-byte codes, extra zeros,
        // zero header byte, type 63, start byte on the final byte
        warmup = '{8'hAB, 8'h00,
                   8'h00, 8'h00, 8'h00, hns_pkg::START_BYTE, 8'h40, 8'hFF,
                   8'h00, 8'h00, hns_pkg::START_BYTE, 8'h42,
                   8'h00, 8'h00, 8'h00, 8'h00, hns_pkg::START_BYTE, 8'h00,
                   8'h00, 8'h00, hns_pkg::START_BYTE, 8'hFE,
                   8'h00, 8'h00, hns_pkg::START_BYTE};
        for (i = 0; i < warmup.size(); i++) begin
            send_byte(warmup[i], i == warmup.size() - 1);
        end
        streams_sent++;

        intervals = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd1,
                      16'($urandom_range(2, 1000)), hns_pkg::INTERVAL_RESET};
        target = bytes_sent;
        for (i = 0; i < intervals.size(); i++) begin
            drain();
            write_interval(intervals[i]);
            burst = (i == 2 || i == 4);
            target += BYTES_PER_PHASE;
            while (bytes_sent < target) send_stream();
        end
        drain();
        burst = 1'b0;

        $display("Sent %0d stream bytes in %0d streams; %0d unit records checked",
                 bytes_sent, streams_sent, records_checked);
        $display("frame_interval stepped through %0d settings, including 0 and 65535",
                 intervals.size() + 1);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== hevc_annexb_nal_splitter.f =====
+incdir+design
design/hns_pkg.sv
design/hns_front.sv
design/hns_queue.sv
design/hns_back.sv
design/hevc_annexb_nal_splitter.sv
tb/nal_record_checker.sv
tb/testbench.sv
